@@ src/scalar_inverse_mod_group_order_defines.svh @@
// Assertion macros shared by the scalar inverse block.
// Included by modules that carry concurrent checks; needs clock and reset in scope.
`ifndef SCALAR_INVERSE_MOD_GROUP_ORDER_DEFINES_SVH
`define SCALAR_INVERSE_MOD_GROUP_ORDER_DEFINES_SVH

// same-cycle implication
`define SIMOG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SIMOG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/simog_pkg.sv @@
// Shared constants and state types for the scalar inverse block.
// No dependencies; imported by simog_mulmod and the top level.
`timescale 1ns / 1ps
package simog_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned WordCount = 8;
   localparam int unsigned ValWidth  = WordWidth * WordCount;
   localparam int unsigned BitCntW   = $clog2(ValWidth);
   localparam int unsigned WordCntW  = $clog2(WordCount);

   // group order L and exponent L-2
   localparam logic [ValWidth-1:0] GROUP_L =
      256'h1000000000000000000000000000000014def9dea2f79cd65812631a5cf5d3ed;
   localparam logic [ValWidth-1:0] EXP_LM2 =
      256'h1000000000000000000000000000000014def9dea2f79cd65812631a5cf5d3eb;
   localparam logic [BitCntW-1:0] EXP_TOP = 8'd252;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ADD,
      PH_SUB1,
      PH_SUB2
   } mul_phase_type;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT,
      ST_OUTPUT
   } ctrl_state_type;

endpackage

@@ src/scalar_inverse_mod_group_order.sv @@
// Top level of the scalar inverse modulo the group order L.
// Depends on simog_pkg, simog_mulmod and scalar_inverse_mod_group_order_defines.svh.
`timescale 1ns / 1ps
// Usage:
//   Input channel req_*: eight 32-bit words of the scalar, least significant
//   first, each taken when req_valid is high and req_stall is low. req_stall
//   stays high from the eighth word until the last result word is taken.
//   Result channel rsp_*: eight words of scalar^(L-2) mod L, least
//   significant first; rsp_result_last marks the eighth. A high rsp_stall
//   holds the current word and pauses the block; nothing is lost.
//   Each bit-serial modular product takes an add step and two trial
//   subtractions per bit of the multiplier over 256 bits, plus a handoff.
//   A scalar takes one reduction of the operand, 253 squarings and 73
//   products for the set bits of L-2, 327 products in all between the
//   eighth word and the first result word. The run time is set by the
//   single shared shift-add multiplier.
//   A zero scalar gives zero. Reset (synchronous, active high) returns the
//   block to collecting the first word of a scalar.
module scalar_inverse_mod_group_order (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_operand_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_word,
   output logic        rsp_result_last
);
   import simog_pkg::*;
`include "scalar_inverse_mod_group_order_defines.svh"

   ctrl_state_type        state_ff, state_in;
   logic [ValWidth-1:0]   store_ff, store_in;
   logic [ValWidth-1:0]   sred_ff, sred_in;
   logic [ValWidth-1:0]   acc_ff, acc_in;
   logic [WordCntW-1:0]   cnt_ff, cnt_in;
   logic [BitCntW-1:0]    bit_ff, bit_in;
   logic                  start_ff, start_in;
   logic                  mul_done;
   logic [ValWidth-1:0]   mul_a, mul_b, mul_r;
   logic                  req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // operand selection for the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_REDUCE: begin
            mul_a = ValWidth'(1);
            mul_b = store_ff;
         end
         ST_MULT: begin
            mul_a = sred_ff;
            mul_b = acc_ff;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = acc_ff;
         end
      endcase
   end

   simog_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .a_val (mul_a),
      .b_val (mul_b),
      .done  (mul_done),
      .r_val (mul_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         cnt_ff   <= '0;
         bit_ff   <= '0;
         start_ff <= 1'b0;
         acc_ff   <= ValWidth'(1);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bit_ff   <= bit_in;
         start_ff <= start_in;
         acc_ff   <= acc_in;
      end
      store_ff <= store_in;
      sred_ff  <= sred_in;
   end

   // sequencer: operand collection, reduction, exponent scan and result output
   always_comb begin
      state_in = state_ff;
      store_in = store_ff;
      sred_in  = sred_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      start_in = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_take) begin
               store_in = {req_operand_word, store_ff[ValWidth-1:WordWidth]};
               cnt_in   = cnt_ff + 1'b1;
               if (cnt_ff == WordCntW'(WordCount - 1)) begin
                  state_in = ST_REDUCE;
                  start_in = 1'b1;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               sred_in  = mul_r;
               acc_in   = ValWidth'(1);
               bit_in   = EXP_TOP;
               state_in = ST_SQUARE;
               start_in = 1'b1;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               acc_in = mul_r;
               if (EXP_LM2[bit_ff]) begin
                  state_in = ST_MULT;
                  start_in = 1'b1;
               end else if (bit_ff == '0) begin
                  state_in = ST_OUTPUT;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  start_in = 1'b1;
               end
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               acc_in = mul_r;
               if (bit_ff == '0) begin
                  state_in = ST_OUTPUT;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = ST_SQUARE;
                  start_in = 1'b1;
               end
            end
         end
         ST_OUTPUT: begin
            if (rsp_take) begin
               acc_in = {WordWidth'(0), acc_ff[ValWidth-1:WordWidth]};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == WordCntW'(WordCount - 1)) state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   assign req_stall       = (state_ff != ST_COLLECT);
   assign rsp_valid       = (state_ff == ST_OUTPUT);
   assign rsp_result_word = acc_ff[WordWidth-1:0];
   assign rsp_result_last = (cnt_ff == WordCntW'(WordCount - 1));

   // checks
   `SIMOG_ASSERT_NOW(a_done_busy, mul_done,
      (state_ff == ST_REDUCE) || (state_ff == ST_SQUARE) || (state_ff == ST_MULT),
      "multiplier finished outside a compute state")
   `SIMOG_ASSERT_NEXT(a_done_pulse, mul_done, !mul_done, "multiplier done longer than one cycle")
   `SIMOG_ASSERT_NOW(a_result_reduced, $rose(rsp_valid), acc_ff < GROUP_L,
      "result not reduced below L")

endmodule

@@ src/simog_mulmod.sv @@
// Bit-serial modular multiplier: r = a * b mod L, one bit of b per add step and two trial subtractions.
// Depends on simog_pkg. Requires a < L; b may be any 256-bit value.
`timescale 1ns / 1ps
module simog_mulmod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [simog_pkg::ValWidth-1:0] a_val,
   input  logic [simog_pkg::ValWidth-1:0] b_val,
   output logic                          done,
   output logic [simog_pkg::ValWidth-1:0] r_val
);
   import simog_pkg::*;

   mul_phase_type         phase_ff, phase_in;
   logic [ValWidth-1:0]   a_ff, a_in;
   logic [ValWidth-1:0]   b_ff, b_in;
   logic [ValWidth-1:0]   r_ff, r_in;
   logic [BitCntW-1:0]    cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [ValWidth:0]     diff;
   logic [ValWidth-1:0]   sum;

   // datapath: shift-add and trial subtraction of L
   assign sum  = {r_ff[ValWidth-2:0], 1'b0} + (b_ff[ValWidth-1] ? a_ff : '0);
   assign diff = {1'b0, r_ff} - {1'b0, GROUP_L};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
   end

   // sequencer: add step, then two conditional subtractions per bit
   always_comb begin
      phase_in = phase_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               a_in     = a_val;
               b_in     = b_val;
               r_in     = '0;
               cnt_in   = '0;
               phase_in = PH_ADD;
            end
         end
         PH_ADD: begin
            r_in     = sum;
            b_in     = {b_ff[ValWidth-2:0], 1'b0};
            phase_in = PH_SUB1;
         end
         PH_SUB1: begin
            if (!diff[ValWidth]) r_in = diff[ValWidth-1:0];
            phase_in = PH_SUB2;
         end
         PH_SUB2: begin
            if (!diff[ValWidth]) r_in = diff[ValWidth-1:0];
            if (cnt_ff == BitCntW'(ValWidth - 1)) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               phase_in = PH_ADD;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   assign done  = done_ff;
   assign r_val = r_ff;

endmodule
